/* rtl/assert_macros.svh */
//------------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cau_pkg.sv */
//------------------------------------------------------------------------------
// cau_pkg
// Shared constants, codes and types of the complex arithmetic unit.
//------------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int FRAC_BITS = 16;          // fraction bits of Q16.16
  localparam int ITER      = 32;          // quotient bits and root bits
  localparam int QDEPTH    = 4;           // front-to-back queue entries
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_MAG = 3'd4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  // decoded operation class; all zero for an unused code
  typedef struct packed {
    logic add;
    logic sub;
    logic mul;
    logic div;
    logic mag;
  } op_t;

  // queue entry: class plus operands, squared operands already selected
  typedef struct packed {
    op_t                op;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
    logic signed [31:0] sq_x;
    logic signed [31:0] sq_y;
  } q_item_t;

endpackage

`default_nettype wire

/* rtl/complex_arithmetic_unit_top.sv */
//------------------------------------------------------------------------------
// complex_arithmetic_unit_top
// Throughput: one item per cycle; the 32-stage division and root pipeline
// takes a new item every cycle and stalls only while a result waits.
// Reset: synchronous active-low rst_n empties the queue and all pipeline
// valid bits; no result is pending after reset.
//------------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input item
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // a_re[31:0], a_im[63:32], b_re[95:64], b_im[127:96]
  input  wire logic [2:0]   in_tuser,   // cmd[2:0]
  // result item
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // res_re[31:0], res_im[63:32]
  output logic [1:0]        out_tuser   // status[1:0]
);
  import cau_pkg::*;

  // front -> queue
  logic    q_push;
  logic    q_full;
  q_item_t q_in;
  // queue -> back end
  logic    q_pop;
  logic    q_valid;
  q_item_t q_out;

  // Front: decode cmd, select squared operands, push into the queue while
  // it has room; ready depends only on the queue fill, never on the output.
  cau_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  // Queue: absorb items while the back end holds a stalled result.
  cau_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .item_in   (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .item_out  (q_out),
    .not_empty (q_valid)
  );

  // Back end: products, sums, rescale and saturate, then 32 stages of
  // restoring division (both components) and digit-by-digit square root,
  // ending in the output register.
  cau_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

/* rtl/cau_front.sv */
//------------------------------------------------------------------------------
// cau_front
// Accept items, decode the operation and pick the operands to be squared.
//------------------------------------------------------------------------------
`default_nettype none

module cau_front (
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [127:0]     in_tdata,
  input  wire logic [2:0]       in_tuser,
  input  wire logic             q_full,
  output logic                  q_push,
  output cau_pkg::q_item_t      q_item
);
  import cau_pkg::*;

  op_t op;

  always_comb begin
    op = '0;
    unique case (in_tuser)
      CMD_ADD: op.add = 1'b1;
      CMD_SUB: op.sub = 1'b1;
      CMD_MUL: op.mul = 1'b1;
      CMD_DIV: op.div = 1'b1;
      CMD_MAG: op.mag = 1'b1;
      default: op = '0;
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.op   = op;
    q_item.a_re = in_tdata[31:0];
    q_item.a_im = in_tdata[63:32];
    q_item.b_re = in_tdata[95:64];
    q_item.b_im = in_tdata[127:96];
    // magnitude squares A, division squares B for the denominator
    q_item.sq_x = op.mag ? in_tdata[31:0]  : in_tdata[95:64];
    q_item.sq_y = op.mag ? in_tdata[63:32] : in_tdata[127:96];
  end

endmodule

`default_nettype wire

/* rtl/cau_fifo.sv */
//------------------------------------------------------------------------------
// cau_fifo
// Short queue that decouples the front from the arithmetic back end.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cau_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire cau_pkg::q_item_t item_in,
  output logic                  full,
  input  wire logic             pop,
  output cau_pkg::q_item_t      item_out,
  output logic                  not_empty
);
  import cau_pkg::*;

  q_item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign item_out  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  `ASSERT_IMPLIES(a_no_pop_empty, pop, not_empty, "queue popped while empty")
  `ASSERT_IMPLIES(a_no_push_full, push, !full, "queue pushed while full")
  `ASSERT_NEXT(a_fill_count, push && !pop, count_r == $past(count_r) + 1'b1, "queue count slip")

endmodule

`default_nettype wire

/* rtl/cau_back.sv */
//------------------------------------------------------------------------------
// cau_back
// Arithmetic pipeline: products, sums, restoring division and square root.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cau_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire cau_pkg::q_item_t q_item,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [63:0]           out_tdata,
  output logic [1:0]            out_tuser
);
  import cau_pkg::*;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  typedef struct packed {
    logic [63:0] r;     // partial remainder
    logic [31:0] w;     // dividend bits out at the top, quotient bits in below
    logic        neg;
    logic        ovf;
  } div_st_t;

  typedef struct packed {
    logic [33:0] r;
    logic [63:0] src;
    logic [31:0] q;
  } sqr_st_t;

  typedef struct packed {
    op_t                op;
    logic [31:0]        pre_re;
    logic [31:0]        pre_im;
    logic               pre_ovf;
    logic signed [63:0] p0;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [63:0] p3;
    logic signed [63:0] p4;
    logic signed [63:0] p5;
  } s1_t;

  typedef struct packed {
    op_t                op;
    logic [31:0]        pre_re;
    logic [31:0]        pre_im;
    logic               pre_ovf;
    logic signed [64:0] mre;
    logic signed [64:0] mim;
    logic signed [64:0] nre;
    logic signed [64:0] nim;
    logic [63:0]        sqs;
  } s2_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] pre_re;
    logic [31:0] pre_im;
    logic        pre_ovf;
    logic        nre_neg;
    logic [63:0] nre_mag;
    logic        nim_neg;
    logic [63:0] nim_mag;
    logic [63:0] sqs;
    logic        dz;
  } s3_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] pre_re;
    logic [31:0] pre_im;
    logic        pre_ovf;
    logic        dz;
    logic [63:0] den;
    div_st_t     dre;
    div_st_t     dim;
    sqr_st_t     sq;
  } it_t;

  localparam logic signed [64:0] MAXV = 65'sd2147483647;
  localparam logic signed [64:0] MINV = -65'sd2147483648;

  function automatic sat_t sat_to32(input logic signed [64:0] v);
    sat_t s;
    if (v > MAXV) begin
      s.val = 32'h7FFF_FFFF;
      s.ovf = 1'b1;
    end else if (v < MINV) begin
      s.val = 32'h8000_0000;
      s.ovf = 1'b1;
    end else begin
      s.val = v[31:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

  function automatic div_st_t div_step(input div_st_t s, input logic [63:0] den);
    div_st_t     n;
    logic [64:0] r2;
    logic [64:0] diff;
    logic        ge;
    n    = s;
    r2   = {s.r, s.w[31]};
    diff = r2 - {1'b0, den};
    ge   = (r2 >= {1'b0, den});
    n.r  = ge ? diff[63:0] : r2[63:0];
    n.w  = {s.w[30:0], ge};
    return n;
  endfunction

  function automatic sqr_st_t sqr_step(input sqr_st_t s);
    sqr_st_t     n;
    logic [35:0] r2;
    logic [35:0] t;
    logic [35:0] diff;
    logic        ge;
    r2    = {s.r, s.src[63:62]};
    t     = {2'b00, s.q, 2'b01};
    diff  = r2 - t;
    ge    = (r2 >= t);
    n.r   = ge ? diff[33:0] : r2[33:0];
    n.q   = {s.q[30:0], ge};
    n.src = {s.src[61:0], 2'b00};
    return n;
  endfunction

  function automatic it_t iter_step(input it_t s);
    it_t n;
    n     = s;
    n.dre = div_step(s.dre, s.den);
    n.dim = div_step(s.dim, s.den);
    n.sq  = sqr_step(s.sq);
    return n;
  endfunction

  function automatic sat_t div_out(input div_st_t d);
    sat_t s;
    if (d.neg) begin
      s.ovf = d.ovf || (d.w > 32'h8000_0000);
      s.val = s.ovf ? 32'h8000_0000 : (32'd0 - d.w);
    end else begin
      s.ovf = d.ovf || d.w[31];
      s.val = s.ovf ? 32'h7FFF_FFFF : d.w;
    end
    return s;
  endfunction

  logic adv;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  it_t  it_r [ITER+1];
  it_t  it0_nxt;
  logic v1_r, v2_r, v3_r;
  logic [ITER:0] itv_r;
  logic        out_valid_r;
  logic [31:0] out_re_r, out_re_nxt;
  logic [31:0] out_im_r, out_im_nxt;
  logic [1:0]  out_st_r, out_st_nxt;

  // advance everything when the output register is free or being drained
  assign adv   = !out_valid_r || out_tready;
  assign q_pop = adv && q_valid;

  // products and the add / subtract result
  always_comb begin
    sat_t        sr;
    sat_t        si;
    logic signed [64:0] sum_re;
    logic signed [64:0] sum_im;
    if (q_item.op.sub) begin
      sum_re = 65'(q_item.a_re) - 65'(q_item.b_re);
      sum_im = 65'(q_item.a_im) - 65'(q_item.b_im);
    end else begin
      sum_re = 65'(q_item.a_re) + 65'(q_item.b_re);
      sum_im = 65'(q_item.a_im) + 65'(q_item.b_im);
    end
    sr = sat_to32(sum_re);
    si = sat_to32(sum_im);
    s1_nxt.op      = q_item.op;
    s1_nxt.pre_re  = sr.val;
    s1_nxt.pre_im  = si.val;
    s1_nxt.pre_ovf = sr.ovf || si.ovf;
    s1_nxt.p0      = q_item.a_re * q_item.b_re;
    s1_nxt.p1      = q_item.a_im * q_item.b_im;
    s1_nxt.p2      = q_item.a_re * q_item.b_im;
    s1_nxt.p3      = q_item.a_im * q_item.b_re;
    s1_nxt.p4      = q_item.sq_x * q_item.sq_x;
    s1_nxt.p5      = q_item.sq_y * q_item.sq_y;
  end

  // exact sums of products
  always_comb begin
    s2_nxt.op      = s1_r.op;
    s2_nxt.pre_re  = s1_r.pre_re;
    s2_nxt.pre_im  = s1_r.pre_im;
    s2_nxt.pre_ovf = s1_r.pre_ovf;
    s2_nxt.mre     = 65'(s1_r.p0) - 65'(s1_r.p1);
    s2_nxt.mim     = 65'(s1_r.p2) + 65'(s1_r.p3);
    s2_nxt.nre     = 65'(s1_r.p0) + 65'(s1_r.p1);
    s2_nxt.nim     = 65'(s1_r.p3) - 65'(s1_r.p2);
    s2_nxt.sqs     = s1_r.p4 + s1_r.p5;
  end

  // product rescale and saturate, numerator magnitudes
  always_comb begin
    sat_t        mr;
    sat_t        mi;
    logic [64:0] neg_re;
    logic [64:0] neg_im;
    mr     = sat_to32(s2_r.mre >>> FRAC_BITS);
    mi     = sat_to32(s2_r.mim >>> FRAC_BITS);
    neg_re = -s2_r.nre;
    neg_im = -s2_r.nim;
    s3_nxt.op      = s2_r.op;
    s3_nxt.pre_re  = s2_r.op.mul ? mr.val : s2_r.pre_re;
    s3_nxt.pre_im  = s2_r.op.mul ? mi.val : s2_r.pre_im;
    s3_nxt.pre_ovf = s2_r.op.mul ? (mr.ovf || mi.ovf) : s2_r.pre_ovf;
    s3_nxt.nre_neg = s2_r.nre[64];
    s3_nxt.nre_mag = s2_r.nre[64] ? neg_re[63:0] : s2_r.nre[63:0];
    s3_nxt.nim_neg = s2_r.nim[64];
    s3_nxt.nim_mag = s2_r.nim[64] ? neg_im[63:0] : s2_r.nim[63:0];
    s3_nxt.sqs     = s2_r.sqs;
    s3_nxt.dz      = (s2_r.sqs == '0);
  end

  // set up the division and root iterations; flag quotients of 2^32 or more
  always_comb begin
    logic [63:0] r_re;
    logic [63:0] r_im;
    r_re = s3_r.nre_mag >> (32 - FRAC_BITS);
    r_im = s3_r.nim_mag >> (32 - FRAC_BITS);
    it0_nxt.op      = s3_r.op;
    it0_nxt.pre_re  = s3_r.pre_re;
    it0_nxt.pre_im  = s3_r.pre_im;
    it0_nxt.pre_ovf = s3_r.pre_ovf;
    it0_nxt.dz      = s3_r.dz;
    it0_nxt.den     = s3_r.sqs;
    it0_nxt.dre.r   = r_re;
    it0_nxt.dre.w   = {s3_r.nre_mag[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
    it0_nxt.dre.neg = s3_r.nre_neg;
    it0_nxt.dre.ovf = (r_re >= s3_r.sqs);
    it0_nxt.dim.r   = r_im;
    it0_nxt.dim.w   = {s3_r.nim_mag[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
    it0_nxt.dim.neg = s3_r.nim_neg;
    it0_nxt.dim.ovf = (r_im >= s3_r.sqs);
    it0_nxt.sq.r    = '0;
    it0_nxt.sq.src  = s3_r.sqs;
    it0_nxt.sq.q    = '0;
  end

  // pick the result by operation class
  always_comb begin
    sat_t dr;
    sat_t di;
    logic ovf;
    dr         = div_out(it_r[ITER].dre);
    di         = div_out(it_r[ITER].dim);
    out_re_nxt = '0;
    out_im_nxt = '0;
    out_st_nxt = ST_OK;
    ovf        = 1'b0;
    priority if (it_r[ITER].op.div) begin
      if (it_r[ITER].dz) begin
        out_st_nxt = ST_DZ;
      end else begin
        out_re_nxt = dr.val;
        out_im_nxt = di.val;
        ovf        = dr.ovf || di.ovf;
      end
    end else if (it_r[ITER].op.mag) begin
      ovf        = it_r[ITER].sq.q[31];
      out_re_nxt = ovf ? 32'h7FFF_FFFF : it_r[ITER].sq.q;
    end else if (it_r[ITER].op.add || it_r[ITER].op.sub || it_r[ITER].op.mul) begin
      out_re_nxt = it_r[ITER].pre_re;
      out_im_nxt = it_r[ITER].pre_im;
      ovf        = it_r[ITER].pre_ovf;
    end else begin
      ovf = 1'b0;
    end
    if (ovf) begin
      out_st_nxt = ST_OVF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      itv_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= q_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      itv_r       <= {itv_r[ITER-1:0], v3_r};
      out_valid_r <= itv_r[ITER];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r     <= s1_nxt;
      s2_r     <= s2_nxt;
      s3_r     <= s3_nxt;
      it_r[0]  <= it0_nxt;
      out_re_r <= out_re_nxt;
      out_im_r <= out_im_nxt;
      out_st_r <= out_st_nxt;
    end
  end

  // one quotient bit of each division and one root bit per stage
  for (genvar k = 1; k <= ITER; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (adv) begin
        it_r[k] <= iter_step(it_r[k-1]);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_im_r, out_re_r};
  assign out_tuser  = out_st_r;

  `ASSERT_NEXT(a_stall_hold, !adv, $stable({v1_r, v2_r, v3_r, itv_r}), "stalled pipe moved")
  `ASSERT_IMPLIES(a_dz_zero, out_valid_r && (out_st_r == ST_DZ), out_tdata == '0, "dz not zero")
  `ASSERT_IMPLIES(a_status_code, out_valid_r, out_st_r <= ST_OVF, "undefined status code")

endmodule

`default_nettype wire

/* dv/tb_complex_arithmetic_unit_top.sv */
//------------------------------------------------------------------------------
// tb_complex_arithmetic_unit_top
// Self-checking bench for the complex arithmetic unit. It sends directed edge
// cases, then random operations with random gaps on both stream sides, and
// checks every result item in order against a wide-arithmetic predictor.
//------------------------------------------------------------------------------
`default_nettype none

module tb_complex_arithmetic_unit_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  localparam int N_RANDOM     = 730;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int LONG_HOLDOFF = 300;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
    bit                 drain;   // wait until all results are back first
  } op_item_t;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  status;
  } cplx_res_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;    // a_re, a_im, b_re, b_im from bit 0 up
  logic [2:0]   in_tuser;    // cmd
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;   // res_re, res_im from bit 0 up
  logic [1:0]   out_tuser;   // status

  op_item_t  pending_ops[$];
  cplx_res_t expected_res[$];
  op_item_t  cur_op;
  bit        sending;
  int        send_gap;
  int        n_results;
  int        n_errors;
  int        cycles;

  complex_arithmetic_unit_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Clamp a wide value to 32 bits; bit 32 flags saturation.
  function automatic logic [32:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sh7FFFFFFF) return {1'b1, 32'h7FFFFFFF};
    if (v < -128'sh80000000) return {1'b1, 32'h80000000};
    return {1'b0, v[31:0]};
  endfunction

  // Truncated square root of a value below 2^64.
  function automatic logic [127:0] floor_sqrt(input logic [127:0] s);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  // Divide a signed numerator by a positive denominator, scaled by the
  // fraction bits, truncated toward zero.
  function automatic logic signed [127:0] scaled_quot(input logic signed [127:0] num,
                                                      input logic signed [127:0] den);
    logic signed [127:0] m;
    logic signed [127:0] q;
    m = (num < 0) ? -num : num;
    q = (m <<< FRAC_BITS) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic cplx_res_t complex_result(input op_item_t op);
    cplx_res_t           r;
    logic signed [127:0] ar, ai, br, bi, den, vr, vi;
    logic [32:0]         cr, ci;
    ar = op.a_re; ai = op.a_im; br = op.b_re; bi = op.b_im;
    vr = 0; vi = 0;
    r.status = ST_OK;
    case (op.cmd)
      CMD_ADD: begin vr = ar + br; vi = ai + bi; end
      CMD_SUB: begin vr = ar - br; vi = ai - bi; end
      CMD_MUL: begin
        // arithmetic shift floors the exact product sums
        vr = (ar * br - ai * bi) >>> FRAC_BITS;
        vi = (ar * bi + ai * br) >>> FRAC_BITS;
      end
      CMD_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.status = ST_DZ;
        else begin
          vr = scaled_quot(ar * br + ai * bi, den);
          vi = scaled_quot(ai * br - ar * bi, den);
        end
      end
      CMD_MAG: vr = floor_sqrt(ar * ar + ai * ai);
      default: ;
    endcase
    cr = clamp32(vr);
    ci = clamp32(vi);
    r.re = cr[31:0];
    r.im = ci[31:0];
    if (r.status == ST_OK && (cr[32] || ci[32])) r.status = ST_OVF;
    return r;
  endfunction

  // Operand mix: extremes, small Q16.16 values, fractions and full range.
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: case ($urandom_range(0, 4))
           0: return 32'h7FFFFFFF;
           1: return 32'h80000000;
           2: return 32'h0;
           3: return 32'h1;
           default: return 32'hFFFFFFFF;
         endcase
      1, 2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0008_0000)
                                         : -$urandom_range(0, 32'h0008_0000);
      3: return $urandom_range(0, 1) ? $urandom_range(0, 32'hFFFF)
                                      : -$urandom_range(0, 32'hFFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] rand_cmd();
    return ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
  endfunction

  task automatic queue_op(input logic [2:0] cmd, input logic [31:0] ar, input logic [31:0] ai,
                          input logic [31:0] br, input logic [31:0] bi, input bit drain);
    op_item_t op;
    op.cmd = cmd; op.a_re = ar; op.a_im = ai; op.b_re = br; op.b_im = bi;
    op.drain = drain;
    pending_ops.push_back(op);
  endtask

  function automatic int pick_gap();
    case ($urandom_range(0, 9))
      0, 1: return $urandom_range(1, 3);
      2:    return $urandom_range(10, 40);
      default: return 0;
    endcase
  endfunction

  // Driver: predict on acceptance, then advance to the next item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      sending   = 1'b0;
      send_gap  = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_res.push_back(complex_result(cur_op));
        sending = 1'b0;
      end
      if (!sending) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_ops.size() > 0 &&
                     (!pending_ops[0].drain || expected_res.size() == 0)) begin
          cur_op   = pending_ops.pop_front();
          sending  = 1'b1;
          send_gap = pick_gap();
        end
      end
      in_tvalid <= sending;
      in_tdata  <= {cur_op.b_im, cur_op.b_re, cur_op.a_im, cur_op.a_re};
      in_tuser  <= cur_op.cmd;
    end
  end

  // Receiver readiness: random stalls plus one long hold-off that fills the block.
  int  rx_stall;
  int  rx_hold;
  bit  rx_hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      rx_stall     = 0;
      rx_hold      = 0;
      rx_hold_done = 1'b0;
    end else begin
      if (!rx_hold_done && n_results >= 200) begin
        rx_hold      = LONG_HOLDOFF;
        rx_hold_done = 1'b1;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        rx_stall = pick_gap();
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: compare each result item with the oldest prediction.
  always @(posedge clk) begin
    cplx_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expected_res.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result re=%h im=%h status=%0d", $time,
                 out_tdata[31:0], out_tdata[63:32], out_tuser);
      end else begin
        e = expected_res.pop_front();
        if (out_tdata[31:0] !== e.re) begin
          n_errors++;
          $display("%0t: res_re expected %h actual %h", $time, e.re, out_tdata[31:0]);
        end
        if (out_tdata[63:32] !== e.im) begin
          n_errors++;
          $display("%0t: res_im expected %h actual %h", $time, e.im, out_tdata[63:32]);
        end
        if (out_tuser !== e.status) begin
          n_errors++;
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_tuser);
        end
      end
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    n_results = 0;
    n_errors  = 0;
    cycles    = 0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_ADD;
    out_tready = 1'b0;
    cur_op = '{cmd: CMD_ADD, a_re: 0, a_im: 0, b_re: 0, b_im: 0, drain: 0};
    rst_n = 1'b0;

    // Directed: saturation on each operation, zero divisor, magnitude limits,
    // flooring of negative products, unused codes.
    queue_op(CMD_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
    queue_op(CMD_ADD, 32'h00010000, 32'hFFFF0000, 32'h00020000, 32'h00008000, 0);
    queue_op(CMD_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'hFFFFFFFF, 0);
    queue_op(CMD_SUB, 32'h00030000, 32'h00000000, 32'h00010000, 32'h00050000, 0);
    queue_op(CMD_MUL, 32'h00020000, 32'h00030000, 32'h00040000, 32'hFFFB0000, 0);
    queue_op(CMD_MUL, 32'hFFFFFFFF, 32'h00000000, 32'h00000001, 32'h00000000, 0);
    queue_op(CMD_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    queue_op(CMD_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0);
    queue_op(CMD_DIV, 32'h00010000, 32'h00020000, 32'h00000000, 32'h00000000, 0);
    queue_op(CMD_DIV, 32'h00060000, 32'hFFFC0000, 32'h00020000, 32'h00010000, 0);
    queue_op(CMD_DIV, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'h00000000, 0);
    queue_op(CMD_DIV, 32'hFFFFFFFF, 32'h00000001, 32'h00030000, 32'hFFFF0000, 0);
    queue_op(CMD_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    queue_op(CMD_DIV, 32'h00000000, 32'h00000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    queue_op(CMD_MAG, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 0);
    queue_op(CMD_MAG, 32'h00030000, 32'hFFFC0000, 32'h0, 32'h0, 0);
    queue_op(CMD_MAG, 32'h00000000, 32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
    queue_op(CMD_MAG, 32'h7FFFFFFF, 32'h00000000, 32'h0, 32'h0, 0);
    queue_op(3'd5, 32'h12345678, 32'h9ABCDEF0, 32'h1, 32'h2, 0);
    queue_op(3'd6, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
    queue_op(3'd7, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, 0);

    // Random part; one item midway waits for the pipeline to drain.
    for (int i = 0; i < N_RANDOM; i++)
      queue_op(rand_cmd(), rand_operand(), rand_operand(), rand_operand(),
               rand_operand(), i == N_RANDOM / 2);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || sending || expected_res.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
    if (n_errors == 0 && expected_res.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_fifo.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit_top.sv
dv/tb_complex_arithmetic_unit_top.sv
